// File: hdl/pfcu_pkg.sv
// Shared constants, types and helper functions for the parallel flash command unit.
package pfcu_pkg;

  localparam int SEGMENT_BYTES = 65536;
  localparam int SEG_AW        = $clog2(SEGMENT_BYTES);
  localparam int OFF_W         = 16;
  localparam int SIZE_W        = 4;
  localparam int VAL_W         = 16;
  localparam int DATA_W        = 64;
  localparam int BYTE_W        = 8;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int MAX_BYTES     = 8;

  localparam logic [VAL_W-1:0] MODE_NONE    = 16'h0000;
  localparam logic [VAL_W-1:0] MODE_ID      = 16'h9090;
  localparam logic [VAL_W-1:0] MODE_STATUS  = 16'h7070;
  localparam logic [VAL_W-1:0] MODE_ESR     = 16'h7171;
  localparam logic [VAL_W-1:0] MODE_CLEAR   = 16'h5050;
  localparam logic [VAL_W-1:0] MODE_PROGRAM = 16'h4040;
  localparam logic [VAL_W-1:0] MODE_ERASE   = 16'h2020;
  localparam logic [VAL_W-1:0] ERASE_OK     = 16'hD0D0;
  localparam logic [VAL_W-1:0] MODE_ARRAY   = 16'hFFFF;
  localparam logic [VAL_W-1:0] READY_BIT    = 16'h0080;
  localparam logic [VAL_W-1:0] MFG_CODE     = 16'h00B0;
  localparam logic [VAL_W-1:0] DEV_CODE     = 16'h66A8;
  localparam logic [VAL_W-1:0] NO_CODE      = 16'hFFFF;
  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  localparam logic WIN_COMMAND = 1'b0;
  localparam logic WIN_SEGMENT = 1'b1;
  localparam logic OP_READ     = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // Register word index, taken from paddr[2]
  localparam logic REG_ROM_PRESENT = 1'b0;

  // Number of shifted subtract steps needed to reduce a 16-bit offset
  function automatic int mod_steps();
    longint lim;
    int     n;
    lim = longint'(SEGMENT_BYTES);
    n   = 0;
    while ((lim << n) <= longint'((1 << OFF_W) - 1)) begin
      n++;
    end
    return n;
  endfunction

  localparam int MOD_STEPS = mod_steps();
  localparam int MSTEP_W   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam logic [MSTEP_W-1:0] MSTEP_INIT =
    MSTEP_W'((MOD_STEPS > 0) ? (MOD_STEPS - 1) : 0);

  function automatic logic [OFF_W-1:0] mod_divisor(logic [MSTEP_W-1:0] k);
    longint d;
    d = longint'(SEGMENT_BYTES) << k;
    return OFF_W'(d);
  endfunction

  // Pick the byte lane of a halfword answer for single-byte accesses
  function automatic logic [VAL_W-1:0] half_answer(logic [VAL_W-1:0] val, logic odd,
                                                   logic wide);
    logic [VAL_W-1:0] res;
    if (wide) begin
      res = val;
    end else if (odd) begin
      res = {8'h00, val[7:0]};
    end else begin
      res = {8'h00, val[15:8]};
    end
    return res;
  endfunction

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_EXEC,
    ST_WR_LO,
    ST_READ,
    ST_DONE
  } pfcu_state_t;

endpackage

// File: hdl/pfcu_in_if.sv
// Input channel: one bus access per item.
interface pfcu_in_if;
  import pfcu_pkg::*;

  logic              valid;
  logic              ready;
  logic              window;
  logic              opcode;
  logic [OFF_W-1:0]  offset;
  logic [SIZE_W-1:0] access_size;
  logic [VAL_W-1:0]  write_data;

  modport source (output valid, window, opcode, offset, access_size, write_data,
                  input ready);
  modport sink   (input valid, window, opcode, offset, access_size, write_data,
                  output ready);
endinterface

// File: hdl/pfcu_out_if.sv
// Result channel: one read answer per item.
interface pfcu_out_if;
  import pfcu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              rom_fetch;

  modport source (output valid, read_data, rom_fetch, input ready);
  modport sink   (input valid, read_data, rom_fetch, output ready);
endinterface

// File: hdl/pfcu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/parallel_flash_command_unit.sv
// Parallel flash command unit: command decode, segment byte store and read sequencer.
// One item at a time. After acceptance the offset is reduced in ST_MOD (no steps
// for a 64 KiB segment), decoded in ST_EXEC, then a read answer goes to the output register.
// Segment data reads walk the byte store in ST_READ, one byte a cycle.
// Writes end in ST_EXEC or ST_WR_LO; an erase confirm sweeps the store in ST_CLEAR.
// Reset clears control state and runs the same sweep of the store (no items).
module parallel_flash_command_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  pfcu_in_if.sink                    in_bus,
  pfcu_out_if.source                 out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfcu_pkg::CFG_AW-1:0] paddr,
  input  logic [pfcu_pkg::CFG_DW-1:0] pwdata,
  output logic [pfcu_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import pfcu_pkg::*;

  localparam logic [SEG_AW:0]   SEG_LIM  = (SEG_AW + 1)'(SEGMENT_BYTES);
  localparam logic [SEG_AW-1:0] CLR_LAST = SEG_AW'(SEGMENT_BYTES - 1);

  pfcu_state_t state_r, state_nxt;

  logic               rom_present_r, rom_present_nxt;
  logic [VAL_W-1:0]   mode_r, mode_nxt;
  logic               prog_armed_r, prog_armed_nxt;
  logic               erase_armed_r, erase_armed_nxt;
  logic [SEG_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [MSTEP_W-1:0] mstep_r, mstep_nxt;
  logic [SIZE_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               window_r, window_nxt;
  logic               opcode_r, opcode_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [VAL_W-1:0]   wval_r, wval_nxt;
  logic [OFF_W-1:0]   rem_r, rem_nxt;
  logic               rd_oob_r, rd_oob_nxt;
  logic [DATA_W-1:0]  res_data_r, res_data_nxt;
  logic               res_fetch_r, res_fetch_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic               out_fetch_r, out_fetch_nxt;

  logic               ram_we;
  logic [SEG_AW-1:0]  ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [SEG_AW-1:0]  ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic [SEG_AW-1:0]  seg_off;
  logic [SEG_AW:0]    lo_addr;
  logic [SEG_AW:0]    rd_addr;
  logic [OFF_W-1:0]   mod_div;
  logic               status_mode;
  logic               seg_cmd;
  logic               erase_go;
  logic               seg_store;
  logic               wide;
  logic               cmd_valid;
  logic [VAL_W-1:0]   id_val;
  logic [BYTE_W-1:0]  rd_byte;
  logic               out_load;
  logic               cfg_wr;

  pfcu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SEGMENT_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode helpers
  always_comb begin
    seg_off     = SEG_AW'(rem_r);
    lo_addr     = {1'b0, seg_off} + (SEG_AW + 1)'(1);
    rd_addr     = {1'b0, seg_off} + (SEG_AW + 1)'(iss_cnt_r);
    mod_div     = mod_divisor(mstep_r);
    status_mode = (mode_r == MODE_STATUS) || (mode_r == MODE_ESR);
    cmd_valid   = (wval_r == MODE_ID) || (wval_r == MODE_STATUS) ||
                  (wval_r == MODE_ESR) || (wval_r == MODE_CLEAR) ||
                  (wval_r == MODE_ARRAY);
    seg_cmd     = (wval_r == MODE_PROGRAM) || (wval_r == MODE_ERASE) ||
                  (wval_r == MODE_STATUS) || (wval_r == MODE_ESR) ||
                  (wval_r == MODE_CLEAR) || (wval_r == MODE_ARRAY);
    erase_go    = erase_armed_r && (wval_r == ERASE_OK);
    seg_store   = prog_armed_r || (!erase_go && !seg_cmd);
    wide        = (size_r >= SIZE_W'(2));
    case (off_r[7:1])
      7'd0:    id_val = MFG_CODE;
      7'd1:    id_val = DEV_CODE;
      default: id_val = NO_CODE;
    endcase
    rd_byte     = rd_oob_r ? ERASED_BYTE : ram_rdata;
    out_load    = (state_r == ST_DONE) && (!out_valid_r || out_bus.ready);
    cfg_wr      = psel && penable && pwrite && (paddr[2] == REG_ROM_PRESENT);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = (MOD_STEPS > 0) ? ST_MOD : ST_EXEC;
        end
      end
      ST_MOD: begin
        if (mstep_r == '0) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (opcode_r == OP_WRITE) begin
          if (window_r == WIN_COMMAND) begin
            state_nxt = ST_IDLE;
          end else if (seg_store) begin
            state_nxt = ST_WR_LO;
          end else if (erase_go) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (size_r == '0 || window_r == WIN_COMMAND) begin
          state_nxt = ST_DONE;
        end else if (!wide || size_r == SIZE_W'(2)) begin
          state_nxt = status_mode ? ST_DONE : ST_READ;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_WR_LO: state_nxt = ST_IDLE;
      ST_READ: begin
        if (iss_cnt_r == size_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rom_present_nxt = cfg_wr ? pwdata[0] : rom_present_r;
    mode_nxt        = mode_r;
    prog_armed_nxt  = prog_armed_r;
    erase_armed_nxt = erase_armed_r;
    clr_addr_nxt    = clr_addr_r;
    mstep_nxt       = mstep_r;
    iss_cnt_nxt     = iss_cnt_r;
    rd_pend_nxt     = 1'b0;
    window_nxt      = window_r;
    opcode_nxt      = opcode_r;
    off_nxt         = off_r;
    size_nxt        = size_r;
    wval_nxt        = wval_r;
    rem_nxt         = rem_r;
    rd_oob_nxt      = rd_oob_r;
    res_data_nxt    = res_data_r;
    res_fetch_nxt   = res_fetch_r;
    ram_we          = 1'b0;
    ram_waddr       = seg_off;
    ram_wdata       = wval_r[15:8];
    ram_raddr       = rd_addr[SEG_AW-1:0];
    in_bus.ready    = (state_r == ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = ERASED_BYTE;
        clr_addr_nxt = clr_addr_r + SEG_AW'(1);
      end
      ST_IDLE: begin
        if (in_bus.valid) begin
          window_nxt = in_bus.window;
          opcode_nxt = in_bus.opcode;
          off_nxt    = in_bus.offset;
          rem_nxt    = in_bus.offset;
          wval_nxt   = in_bus.write_data;
          size_nxt   = (in_bus.access_size > SIZE_W'(MAX_BYTES)) ? SIZE_W'(MAX_BYTES)
                                                               : in_bus.access_size;
          mstep_nxt  = MSTEP_INIT;
        end
      end
      ST_MOD: begin
        // Restoring reduction of the offset, one shifted segment size a step
        if (rem_r >= mod_div) begin
          rem_nxt = rem_r - mod_div;
        end
        mstep_nxt = mstep_r - MSTEP_W'(1);
      end
      ST_EXEC: begin
        res_data_nxt  = '0;
        res_fetch_nxt = 1'b0;
        iss_cnt_nxt   = '0;
        if (opcode_r == OP_WRITE) begin
          if (window_r == WIN_COMMAND) begin
            if (cmd_valid) begin
              mode_nxt = wval_r;
            end
          end else if (prog_armed_r) begin
            ram_we         = 1'b1;
            prog_armed_nxt = 1'b0;
          end else if (erase_go) begin
            erase_armed_nxt = 1'b0;
            mode_nxt        = MODE_NONE;
            clr_addr_nxt    = '0;
          end else if (wval_r == MODE_PROGRAM) begin
            prog_armed_nxt = 1'b1;
            mode_nxt       = wval_r;
          end else if (wval_r == MODE_ERASE) begin
            erase_armed_nxt = 1'b1;
            mode_nxt        = wval_r;
          end else if (seg_cmd) begin
            mode_nxt = wval_r;
          end else begin
            ram_we = 1'b1;
          end
        end else if (size_r == '0) begin
          res_data_nxt = '0;
        end else if (window_r == WIN_COMMAND) begin
          if (rom_present_r) begin
            if (size_r > SIZE_W'(2)) begin
              res_fetch_nxt = 1'b1;
            end else if (mode_r == MODE_ID) begin
              res_data_nxt = DATA_W'(half_answer(id_val, off_r[0], wide));
            end else if (status_mode) begin
              res_data_nxt = DATA_W'(half_answer(READY_BIT, off_r[0], wide));
            end else begin
              res_fetch_nxt = 1'b1;
            end
          end
        end else if (size_r <= SIZE_W'(2) && status_mode) begin
          res_data_nxt = DATA_W'(half_answer(READY_BIT, off_r[0], wide));
        end
      end
      ST_WR_LO: begin
        // Low byte goes to the next address, dropped past the segment end
        ram_waddr = lo_addr[SEG_AW-1:0];
        ram_wdata = wval_r[7:0];
        ram_we    = (lo_addr < SEG_LIM);
      end
      ST_READ: begin
        if (rd_pend_r) begin
          res_data_nxt = {res_data_r[DATA_W-BYTE_W-1:0], rd_byte};
        end
        if (iss_cnt_r != size_r) begin
          iss_cnt_nxt = iss_cnt_r + SIZE_W'(1);
          rd_pend_nxt = 1'b1;
          rd_oob_nxt  = (rd_addr >= SEG_LIM);
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_bus.ready);
    out_data_nxt  = out_load ? res_data_r : out_data_r;
    out_fetch_nxt = out_load ? res_fetch_r : out_fetch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      rom_present_r <= 1'b1;
      mode_r        <= MODE_NONE;
      prog_armed_r  <= 1'b0;
      erase_armed_r <= 1'b0;
      clr_addr_r    <= '0;
      mstep_r       <= '0;
      iss_cnt_r     <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rom_present_r <= rom_present_nxt;
      mode_r        <= mode_nxt;
      prog_armed_r  <= prog_armed_nxt;
      erase_armed_r <= erase_armed_nxt;
      clr_addr_r    <= clr_addr_nxt;
      mstep_r       <= mstep_nxt;
      iss_cnt_r     <= iss_cnt_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    window_r    <= window_nxt;
    opcode_r    <= opcode_nxt;
    off_r       <= off_nxt;
    size_r      <= size_nxt;
    wval_r      <= wval_nxt;
    rem_r       <= rem_nxt;
    rd_oob_r    <= rd_oob_nxt;
    res_data_r  <= res_data_nxt;
    res_fetch_r <= res_fetch_nxt;
    out_data_r  <= out_data_nxt;
    out_fetch_r <= out_fetch_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;
  assign out_bus.rom_fetch = out_fetch_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROM_PRESENT) ? CFG_DW'(rom_present_r) : '0;

endmodule

// File: bench/parallel_flash_command_unit_test.sv
// Self-checking bench for the flash command unit: directed table, then random bus accesses.
`timescale 1ns / 100ps

module parallel_flash_command_unit_test;
  import pfcu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_AW-1:0] ROM_PRESENT_ADDR = CFG_AW'(4 * int'(REG_ROM_PRESENT));

  typedef struct packed {
    logic              window;
    logic              opcode;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [VAL_W-1:0]  wdata;
    logic              typed;
    logic [DATA_W-1:0] t_data;
    logic              t_fetch;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              fetch;
  } answer_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  pfcu_in_if  in_bus ();
  pfcu_out_if out_bus ();

  parallel_flash_command_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted flash state
  logic [BYTE_W-1:0] seg_m [SEGMENT_BYTES];
  logic [VAL_W-1:0]  mode_m = MODE_NONE;
  logic              prog_m = 1'b0;
  logic              erase_m = 1'b0;
  logic              rom_m = 1'b1;

  access_t access_q [$];
  access_t directed_rows [$];
  answer_t answer_q [$];
  access_t on_bus;

  int rand_left = 0;
  int erase_left = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic send_hold = 1'b0;
  int stall_tag = 0;
  int stall_len = 0;
  int rx_seen_tag = 0;
  int rx_stall_left = 0;

  int n_bad = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_erase = 0;
  int n_rom_writes = 0;
  int unsigned n_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic is_mode_code(logic [VAL_W-1:0] v);
    return v == MODE_ID || v == MODE_STATUS || v == MODE_ESR ||
           v == MODE_CLEAR || v == MODE_ARRAY;
  endfunction

  function automatic logic [DATA_W-1:0] lane_pick(logic [VAL_W-1:0] v, logic odd,
                                                  int unsigned sz);
    if (sz >= 2) return DATA_W'(v);
    return odd ? DATA_W'(v[7:0]) : DATA_W'(v[15:8]);
  endfunction

  task automatic store_pair(int unsigned o, logic [VAL_W-1:0] v);
    seg_m[o] = v[15:8];
    if (o + 1 < SEGMENT_BYTES) seg_m[o + 1] = v[7:0];
  endtask

  // Advance the predicted state by one access and work out its answer
  task automatic predict_flash_answer(input access_t a, output logic has_res,
                                      output answer_t ans);
    int unsigned sz;
    int unsigned o;
    int unsigned p;
    logic [VAL_W-1:0] hv;
    logic status;
    has_res = 1'b0;
    ans = '0;
    sz = (a.size > MAX_BYTES) ? MAX_BYTES : a.size;
    o = a.offset % SEGMENT_BYTES;
    status = (mode_m == MODE_STATUS) || (mode_m == MODE_ESR);
    if (a.opcode == OP_WRITE) begin
      if (a.window == WIN_COMMAND) begin
        if (is_mode_code(a.wdata)) mode_m = a.wdata;
      end else if (prog_m) begin
        store_pair(o, a.wdata);
        prog_m = 1'b0;
      end else if (erase_m && a.wdata == ERASE_OK) begin
        foreach (seg_m[i]) seg_m[i] = ERASED_BYTE;
        erase_m = 1'b0;
        mode_m = MODE_NONE;
        n_erase++;
      end else if (a.wdata == MODE_PROGRAM) begin
        prog_m = 1'b1;
        mode_m = a.wdata;
      end else if (a.wdata == MODE_ERASE) begin
        erase_m = 1'b1;
        mode_m = a.wdata;
      end else if (a.wdata != MODE_ID && is_mode_code(a.wdata)) begin
        mode_m = a.wdata;
      end else begin
        store_pair(o, a.wdata);
      end
    end else begin
      has_res = 1'b1;
      if (sz == 0) begin
        ans = '0;
      end else if (a.window == WIN_COMMAND) begin
        if (rom_m) begin
          if (sz > 2) begin
            ans.fetch = 1'b1;
          end else if (mode_m == MODE_ID) begin
            case (a.offset[7:0] & 8'hFE)
              8'h00:   hv = MFG_CODE;
              8'h02:   hv = DEV_CODE;
              default: hv = NO_CODE;
            endcase
            ans.data = lane_pick(hv, a.offset[0], sz);
          end else if (status) begin
            ans.data = lane_pick(READY_BIT, a.offset[0], sz);
          end else begin
            ans.fetch = 1'b1;
          end
        end
      end else if (sz <= 2 && status) begin
        ans.data = lane_pick(READY_BIT, a.offset[0], sz);
      end else begin
        for (p = 0; p < sz; p++) begin
          ans.data = {ans.data[DATA_W-BYTE_W-1:0],
                      (o + p < SEGMENT_BYTES) ? seg_m[o + p] : ERASED_BYTE};
        end
      end
    end
  endtask

  function automatic access_t make_access(logic win, logic op, logic [OFF_W-1:0] off,
                                          logic [SIZE_W-1:0] sz, logic [VAL_W-1:0] wd);
    access_t a;
    a = '0;
    a.window = win;
    a.opcode = op;
    a.offset = off;
    a.size = sz;
    a.wdata = wd;
    return a;
  endfunction

  function automatic access_t with_answer(access_t a, logic [DATA_W-1:0] d, logic f);
    a.typed = 1'b1;
    a.t_data = d;
    a.t_fetch = f;
    return a;
  endfunction

  // Mostly the low end of the segment and the top end, where the boundary lies
  function automatic logic [OFF_W-1:0] pick_off();
    int k;
    k = $urandom_range(99);
    if (k < 70) return OFF_W'($urandom_range(63));
    if (k < 85) return OFF_W'($urandom_range(SEGMENT_BYTES - 1, SEGMENT_BYTES - 16));
    return OFF_W'($urandom());
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return SIZE_W'($urandom_range(15, MAX_BYTES + 1));
    return SIZE_W'($urandom_range(MAX_BYTES, 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_code();
    case ($urandom_range(7))
      0:       return MODE_ID;
      1:       return MODE_STATUS;
      2:       return MODE_ESR;
      3:       return MODE_CLEAR;
      4:       return MODE_ARRAY;
      5:       return MODE_PROGRAM;
      6:       return MODE_ERASE;
      default: return ERASE_OK;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_seg_mode();
    case ($urandom_range(3))
      0:       return MODE_STATUS;
      1:       return MODE_ESR;
      2:       return MODE_CLEAR;
      default: return MODE_ARRAY;
    endcase
  endfunction

  // Keep the erase confirm out of plain data so that sweeps stay rare
  function automatic logic [VAL_W-1:0] plain_value();
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom());
    return (v == ERASE_OK) ? ~v : v;
  endfunction

  task automatic push_counted(access_t a);
    access_q.push_back(a);
    rand_left--;
  endtask

  // Plan the next short sequence from the predicted state
  task automatic plan_burst();
    int k;
    int n;
    logic [OFF_W-1:0] o;
    logic [VAL_W-1:0] v;
    access_t a;
    k = $urandom_range(99);
    if (k < 28) begin
      push_counted(make_access(WIN_SEGMENT, OP_READ, pick_off(), pick_size(),
                               VAL_W'($urandom())));
    end else if (k < 42) begin
      o = $urandom_range(1) ? OFF_W'($urandom_range(7)) : OFF_W'($urandom());
      push_counted(make_access(WIN_COMMAND, OP_READ, o, pick_size(), VAL_W'($urandom())));
    end else if (k < 52) begin
      v = ($urandom_range(9) < 7) ? pick_code() : VAL_W'($urandom());
      a = make_access(WIN_COMMAND, OP_WRITE, OFF_W'($urandom()), SIZE_W'($urandom()), v);
      if (is_mode_code(v)) push_counted(a);
      else access_q.push_back(a);
    end else if (k < 70) begin
      push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), SIZE_W'($urandom()),
                               plain_value()));
    end else if (k < 78) begin
      push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), SIZE_W'($urandom()),
                               pick_seg_mode()));
    end else if (k < 88) begin
      o = pick_off();
      v = VAL_W'($urandom());
      if (v == ERASE_OK && (prog_m || erase_m)) v = ~v;
      push_counted(make_access(WIN_SEGMENT, OP_WRITE, OFF_W'($urandom()), 4'd2,
                               MODE_PROGRAM));
      push_counted(make_access(WIN_SEGMENT, OP_WRITE, o, 4'd2, v));
      if ($urandom_range(1))
        push_counted(make_access(WIN_SEGMENT, OP_READ, o, SIZE_W'($urandom_range(8, 2)),
                                 '0));
    end else if (k < 92) begin
      push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), 4'd2, MODE_ERASE));
      if (erase_left > 0) begin
        erase_left--;
        n = $urandom_range(2);
        repeat (n)
          push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), 4'd2,
                                   plain_value()));
        push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), 4'd2, ERASE_OK));
        push_counted(make_access(WIN_SEGMENT, OP_READ, pick_off(), 4'd8, '0));
      end
    end else if (k < 95) begin
      // confirm with nothing armed: stored as plain data
      if (!erase_m && !prog_m)
        push_counted(make_access(WIN_SEGMENT, OP_WRITE, pick_off(), 4'd2, ERASE_OK));
      else
        push_counted(make_access(WIN_SEGMENT, OP_READ, pick_off(), pick_size(), '0));
    end else begin
      a = make_access(1'($urandom()), 1'($urandom()), OFF_W'($urandom()),
                      SIZE_W'($urandom()), VAL_W'($urandom()));
      if (a.window == WIN_SEGMENT && a.opcode == OP_WRITE && a.wdata == ERASE_OK)
        a.wdata[0] = ~a.wdata[0];
      push_counted(a);
    end
  endtask

  always @(posedge clk) begin : tx_side
    logic got;
    answer_t ans;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_flash_answer(on_bus, got, ans);
        if (got) begin
          if (on_bus.typed) answer_q.push_back(answer_t'({on_bus.t_data, on_bus.t_fetch}));
          else answer_q.push_back(ans);
        end
        n_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (access_q.size() == 0 && rand_left > 0) plan_burst();
        if (access_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle) begin
          on_bus = access_q.pop_front();
          in_bus.window      <= on_bus.window;
          in_bus.opcode      <= on_bus.opcode;
          in_bus.offset      <= on_bus.offset;
          in_bus.access_size <= on_bus.size;
          in_bus.write_data  <= on_bus.wdata;
          in_bus.valid       <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_side
    answer_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_checked++;
        if (answer_q.size() == 0) begin
          $error("answer item with nothing expected: read_data %h rom_fetch %b",
                 out_bus.read_data, out_bus.rom_fetch);
          n_bad++;
        end else begin
          want = answer_q.pop_front();
          if (out_bus.read_data !== want.data) begin
            $error("read_data: expected %h, got %h", want.data, out_bus.read_data);
            n_bad++;
          end
          if (out_bus.rom_fetch !== want.fetch) begin
            $error("rom_fetch: expected %b, got %b", want.fetch, out_bus.rom_fetch);
            n_bad++;
          end
        end
      end
      if (stall_tag != rx_seen_tag) begin
        rx_seen_tag = stall_tag;
        rx_stall_left = stall_len;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic write_rom_present(logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROM_PRESENT_ADDR;
    pwdata  <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rom_m = v;
    n_rom_writes++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (rand_left > 0 || access_q.size() != 0 || in_bus.valid || answer_q.size() != 0);
  endtask

  // A read answer proves every earlier write is done
  task automatic settle();
    access_q.push_back(make_access(WIN_SEGMENT, OP_READ, '0, 4'd1, '0));
    drain();
    repeat (20) @(posedge clk);
  endtask

  task automatic build_directed();
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0000, 4'd1, '0),
                                        '0, 1'b1));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0000, 4'd0, '0),
                                        '0, 1'b0));
    directed_rows.push_back(with_answer(make_access(WIN_SEGMENT, OP_READ, 16'h0000, 4'd8, '0),
                                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
    directed_rows.push_back(make_access(WIN_COMMAND, OP_WRITE, 16'h0000, 4'd2, MODE_ID));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0000, 4'd2, '0),
                                        64'h00B0, 1'b0));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0002, 4'd2, '0),
                                        64'h66A8, 1'b0));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0104, 4'd1, '0),
                                        64'hFF, 1'b0));
    // only the low byte of the offset selects the ID halfword
    directed_rows.push_back(make_access(WIN_COMMAND, OP_READ, 16'h0101, 4'd1, '0));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0006, 4'd3, '0),
                                        '0, 1'b1));
    directed_rows.push_back(make_access(WIN_COMMAND, OP_WRITE, 16'h0000, 4'd2, 16'h1234));
    directed_rows.push_back(make_access(WIN_COMMAND, OP_WRITE, 16'h0000, 4'd2, MODE_STATUS));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0001, 4'd1, '0),
                                        64'h80, 1'b0));
    directed_rows.push_back(with_answer(make_access(WIN_SEGMENT, OP_READ, 16'h0009, 4'd2, '0),
                                        64'h0080, 1'b0));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0000, 4'd2, MODE_ARRAY));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'hFFFF, 4'd2, 16'hA55A));
    // armed program takes the next value as data, even a command code
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0000, 4'd2, MODE_PROGRAM));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0010, 4'd2, MODE_ERASE));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_READ, 16'hFFFC, 4'd12, '0));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_READ, 16'h000E, 4'd4, '0));
    // erase stays armed across a plain store, then the confirm sweeps
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0000, 4'd2, MODE_ERASE));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0030, 4'd2, 16'h5A5A));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0000, 4'd2, ERASE_OK));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_READ, 16'h000E, 4'd4, '0));
    directed_rows.push_back(make_access(WIN_SEGMENT, OP_WRITE, 16'h0000, 4'd2, MODE_ESR));
    directed_rows.push_back(make_access(WIN_COMMAND, OP_WRITE, 16'h0000, 4'd2, MODE_CLEAR));
    directed_rows.push_back(with_answer(make_access(WIN_COMMAND, OP_READ, 16'h0000, 4'd2, '0),
                                        '0, 1'b1));
  endtask

  initial begin : main_flow
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid       = 1'b0;
    in_bus.window      = 1'b0;
    in_bus.opcode      = 1'b0;
    in_bus.offset      = '0;
    in_bus.access_size = '0;
    in_bus.write_data  = '0;
    out_bus.ready      = 1'b0;
    foreach (seg_m[i]) seg_m[i] = ERASED_BYTE;
    send_idle = 18;
    recv_idle = 67;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_rom_present(1'b1);

    build_directed();
    foreach (directed_rows[i]) access_q.push_back(directed_rows[i]);
    drain();

    erase_left = 1;
    rand_left = 330;
    drain();

    // swap the idling and run with no boot ROM; pause the sender once midway
    settle();
    write_rom_present(1'b0);
    send_idle = 67;
    recv_idle = 18;
    erase_left = 1;
    rand_left = 330;
    do @(negedge clk); while (rand_left > 160);
    send_hold = 1'b1;
    do @(negedge clk); while (in_bus.valid || answer_q.size() != 0);
    send_hold = 1'b0;
    drain();

    // no idling; hold the receiver off long enough to back up the input
    settle();
    write_rom_present(1'b1);
    send_idle = 0;
    recv_idle = 0;
    erase_left = 1;
    rand_left = 340;
    do @(negedge clk); while (rand_left > 300);
    stall_len = 400;
    stall_tag++;
    drain();
    repeat (30) @(posedge clk);

    $display("covered %0d accepted items, %0d answers checked, %0d store erases,",
             n_accepted, n_checked, n_erase);
    $display("rom_present written %0d times across three idling patterns", n_rom_writes);
    if (n_bad == 0 && answer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
